>>> src/dlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Devanagari transcriber package
// Shared types, code point constants and the letter table of the transcriber.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_NULL  = 21'h000000;
  localparam logic [CP_W-1:0] CP_ZWJ   = 21'h00200d;
  localparam logic [CP_W-1:0] CP_NUKTA = 21'h00093c;
  localparam logic [CP_W-1:0] CP_JA    = 21'h00091c;
  localparam logic [CP_W-1:0] CP_JHA   = 21'h00091d;
  localparam logic [CP_W-1:0] CP_PHA   = 21'h00092b;

  // Upper bits of every point in the range U+0900..U+097F.
  localparam logic [13:0] DEV_BLOCK = 14'h012;

  localparam logic [7:0] CH_SCHWA = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_CONS,
    KIND_VSIGN
  } kind_t;

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_PUSH,
    MODE_EDIT,
    MODE_FLUSH
  } mode_t;

  typedef struct packed {
    logic        listed;
    kind_t       kind;
    logic [1:0]  len;
    logic [23:0] text;
  } glyph_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            listed;
    kind_t           kind;
    logic [2:0]      nbytes;
    logic [31:0]     bytes;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic       lit;
    logic       last;
    logic [7:0] data;
  } emit_t;

  function automatic glyph_t glyph_mk(input kind_t kind, input logic [23:0] txt);
    glyph_t g;
    g.listed = 1'b1;
    g.kind   = kind;
    if (txt[23:16] != 8'h00) begin
      g.len  = 2'd3;
      g.text = txt;
    end else if (txt[15:8] != 8'h00) begin
      g.len  = 2'd2;
      g.text = {txt[15:0], 8'h00};
    end else if (txt[7:0] != 8'h00) begin
      g.len  = 2'd1;
      g.text = {txt[7:0], 16'h0000};
    end else begin
      g.len  = 2'd0;
      g.text = 24'h000000;
    end
    return g;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [6:0] off);
    glyph_t g;
    g = '0;
    unique case (off)
      7'h01: g = glyph_mk(KIND_PLAIN, "n");
      7'h02: g = glyph_mk(KIND_PLAIN, "n");
      7'h03: g = glyph_mk(KIND_PLAIN, "h");
      7'h05: g = glyph_mk(KIND_PLAIN, "a");
      7'h06: g = glyph_mk(KIND_PLAIN, "aa");
      7'h07: g = glyph_mk(KIND_PLAIN, "i");
      7'h08: g = glyph_mk(KIND_PLAIN, "ee");
      7'h09: g = glyph_mk(KIND_PLAIN, "u");
      7'h0a: g = glyph_mk(KIND_PLAIN, "oo");
      7'h0b: g = glyph_mk(KIND_PLAIN, "r");
      7'h0c: g = glyph_mk(KIND_PLAIN, "l");
      7'h0f: g = glyph_mk(KIND_PLAIN, "e");
      7'h10: g = glyph_mk(KIND_PLAIN, "ai");
      7'h11: g = glyph_mk(KIND_PLAIN, "o");
      7'h12: g = glyph_mk(KIND_PLAIN, "o");
      7'h13: g = glyph_mk(KIND_PLAIN, "o");
      7'h14: g = glyph_mk(KIND_PLAIN, "au");
      7'h15: g = glyph_mk(KIND_CONS, "k");
      7'h16: g = glyph_mk(KIND_CONS, "kh");
      7'h17: g = glyph_mk(KIND_CONS, "g");
      7'h18: g = glyph_mk(KIND_CONS, "gh");
      7'h19: g = glyph_mk(KIND_CONS, "n");
      7'h1a: g = glyph_mk(KIND_CONS, "ch");
      7'h1b: g = glyph_mk(KIND_CONS, "chh");
      7'h1c: g = glyph_mk(KIND_CONS, "j");
      7'h1d: g = glyph_mk(KIND_CONS, "jh");
      7'h1e: g = glyph_mk(KIND_CONS, "n");
      7'h1f: g = glyph_mk(KIND_CONS, "t");
      7'h20: g = glyph_mk(KIND_CONS, "th");
      7'h21: g = glyph_mk(KIND_CONS, "d");
      7'h22: g = glyph_mk(KIND_CONS, "dh");
      7'h23: g = glyph_mk(KIND_CONS, "n");
      7'h24: g = glyph_mk(KIND_CONS, "t");
      7'h25: g = glyph_mk(KIND_CONS, "th");
      7'h26: g = glyph_mk(KIND_CONS, "d");
      7'h27: g = glyph_mk(KIND_CONS, "dh");
      7'h28: g = glyph_mk(KIND_CONS, "n");
      7'h2a: g = glyph_mk(KIND_CONS, "p");
      7'h2b: g = glyph_mk(KIND_CONS, "ph");
      7'h2c: g = glyph_mk(KIND_CONS, "b");
      7'h2d: g = glyph_mk(KIND_CONS, "bh");
      7'h2e: g = glyph_mk(KIND_CONS, "m");
      7'h2f: g = glyph_mk(KIND_CONS, "y");
      7'h30: g = glyph_mk(KIND_CONS, "r");
      7'h32: g = glyph_mk(KIND_CONS, "l");
      7'h33: g = glyph_mk(KIND_CONS, "l");
      7'h35: g = glyph_mk(KIND_CONS, "v");
      7'h36: g = glyph_mk(KIND_CONS, "sh");
      7'h37: g = glyph_mk(KIND_CONS, "sh");
      7'h38: g = glyph_mk(KIND_CONS, "s");
      7'h39: g = glyph_mk(KIND_CONS, "h");
      7'h3d: g = glyph_mk(KIND_PLAIN, "'");
      7'h3e: g = glyph_mk(KIND_VSIGN, "aa");
      7'h3f: g = glyph_mk(KIND_VSIGN, "i");
      7'h40: g = glyph_mk(KIND_VSIGN, "ee");
      7'h41: g = glyph_mk(KIND_VSIGN, "u");
      7'h42: g = glyph_mk(KIND_VSIGN, "oo");
      7'h43: g = glyph_mk(KIND_VSIGN, "r");
      7'h44: g = glyph_mk(KIND_VSIGN, "rr");
      7'h47: g = glyph_mk(KIND_VSIGN, "e");
      7'h48: g = glyph_mk(KIND_VSIGN, "ai");
      7'h49: g = glyph_mk(KIND_VSIGN, "o");
      7'h4a: g = glyph_mk(KIND_VSIGN, "o");
      7'h4b: g = glyph_mk(KIND_VSIGN, "o");
      7'h4c: g = glyph_mk(KIND_VSIGN, "au");
      7'h4d: g = glyph_mk(KIND_VSIGN, 24'h000000);
      7'h50: g = glyph_mk(KIND_PLAIN, "aum");
      7'h58: g = glyph_mk(KIND_CONS, "k");
      7'h59: g = glyph_mk(KIND_CONS, "kh");
      7'h5a: g = glyph_mk(KIND_CONS, "g");
      7'h5b: g = glyph_mk(KIND_CONS, "z");
      7'h5c: g = glyph_mk(KIND_CONS, "d");
      7'h5d: g = glyph_mk(KIND_CONS, "dh");
      7'h5e: g = glyph_mk(KIND_CONS, "f");
      7'h60: g = glyph_mk(KIND_PLAIN, "rr");
      7'h61: g = glyph_mk(KIND_PLAIN, "ll");
      7'h62: g = glyph_mk(KIND_VSIGN, "l");
      7'h63: g = glyph_mk(KIND_VSIGN, "ll");
      7'h64: g = glyph_mk(KIND_PLAIN, "|");
      7'h65: g = glyph_mk(KIND_PLAIN, "||");
      7'h66: g = glyph_mk(KIND_PLAIN, "0");
      7'h67: g = glyph_mk(KIND_PLAIN, "1");
      7'h68: g = glyph_mk(KIND_PLAIN, "2");
      7'h69: g = glyph_mk(KIND_PLAIN, "3");
      7'h6a: g = glyph_mk(KIND_PLAIN, "4");
      7'h6b: g = glyph_mk(KIND_PLAIN, "5");
      7'h6c: g = glyph_mk(KIND_PLAIN, "6");
      7'h6d: g = glyph_mk(KIND_PLAIN, "7");
      7'h6e: g = glyph_mk(KIND_PLAIN, "8");
      7'h6f: g = glyph_mk(KIND_PLAIN, "9");
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

>>> src/dlt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/dlt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transcriber front end
// Accepts an item, looks it up in the letter table or encodes it as UTF-8,
// and holds the resulting byte list for the sequencer.
// ----------------------------------------------------------------------------
module dlt_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [dlt_pkg::CP_W-1:0]  in_code_point,
  output logic                           in_stall,
  input  wire logic                      done,
  output logic                           cmd_valid,
  output dlt_pkg::cmd_t                  cmd
);
  import dlt_pkg::*;

  logic   cmd_valid_r;
  logic   cmd_valid_nxt;
  cmd_t   cmd_r;
  cmd_t   cmd_nxt;
  glyph_t g;
  logic   accept;

  assign in_stall = cmd_valid_r && !done;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    g = glyph_lookup(in_code_point[6:0]);
    cmd_nxt.cp     = in_code_point;
    cmd_nxt.listed = g.listed && (in_code_point[20:7] == DEV_BLOCK);
    cmd_nxt.kind   = g.kind;
    if (cmd_nxt.listed) begin
      cmd_nxt.nbytes = {1'b0, g.len} + {2'b00, (g.kind == KIND_CONS)};
      cmd_nxt.bytes  = {g.text, 8'h00};
      if (g.kind == KIND_CONS) begin
        cmd_nxt.bytes = cmd_nxt.bytes | ({CH_SCHWA, 24'h000000} >> {g.len, 3'b000});
      end
    end else if (in_code_point < 21'h000080) begin
      cmd_nxt.nbytes = 3'd1;
      cmd_nxt.bytes  = {in_code_point[7:0], 24'h000000};
    end else if (in_code_point < 21'h000800) begin
      cmd_nxt.nbytes = 3'd2;
      cmd_nxt.bytes  = {3'b110, in_code_point[10:6], 2'b10, in_code_point[5:0], 16'h0000};
    end else if (in_code_point < 21'h010000) begin
      cmd_nxt.nbytes = 3'd3;
      cmd_nxt.bytes  = {4'b1110, in_code_point[15:12], 2'b10, in_code_point[11:6],
                        2'b10, in_code_point[5:0], 8'h00};
    end else begin
      cmd_nxt.nbytes = 3'd4;
      cmd_nxt.bytes  = {5'b11110, in_code_point[20:18], 2'b10, in_code_point[17:12],
                        2'b10, in_code_point[11:6], 2'b10, in_code_point[5:0]};
    end
  end

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (accept) begin
      cmd_valid_nxt = 1'b1;
    end else if (done) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule
`default_nettype wire

>>> src/dlt_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transcriber sequencer
// Works one step per cycle, unless it waits for room in the output queue, on
// the held bytes in the RAM ring: pushes, in-place edits, and the flush at the end of a string.
// ----------------------------------------------------------------------------
module dlt_seq #(
  parameter int HOLD_DEPTH = 3,
  localparam int AW = $clog2(HOLD_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire dlt_pkg::cmd_t cmd,
  output logic               done,
  input  wire logic          credit_ok,
  output dlt_pkg::emit_t     emit,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic [AW-1:0]      ram_raddr
);
  import dlt_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int SW = $clog2(HOLD_DEPTH + 2);
  localparam logic [CW-1:0] FULL = CW'(HOLD_DEPTH);

  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CP_W-1:0] prev_r, prev_nxt;
  logic            emitted_r, emitted_nxt;
  logic            isa_r [HOLD_DEPTH];
  logic            isa_nxt [HOLD_DEPTH];
  logic [SW-1:0]   step_r, step_nxt;
  mode_t           mode_r, mode_nxt;

  logic            first;
  logic            dev_c;
  logic            dev_p;
  logic            held;
  logic            edit0;
  logic            drop0;
  logic            del0;
  mode_t           mode0;
  mode_t           mode;
  logic [CW-1:0]   cnt_eff;
  logic [AW-1:0]   last_pos;
  logic [31:0]     shifted;
  logic [7:0]      push_byte;
  logic            full;
  logic            push_last;

  function automatic logic [AW-1:0] pos(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, h} + (AW+1)'(off);
    if (sum >= (AW+1)'(HOLD_DEPTH)) begin
      sum = sum - (AW+1)'(HOLD_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    first     = (step_r == '0);
    dev_c     = (cmd.cp[20:7] == DEV_BLOCK);
    dev_p     = (prev_r[20:7] == DEV_BLOCK);
    held      = (count_r != '0);
    last_pos  = pos(head_r, count_r - CW'(1));
    edit0     = !cmd.listed && (cmd.cp == CP_NUKTA) && (emitted_r || held);
    drop0     = !cmd.listed && !edit0 && dev_p && !dev_c && held && isa_r[last_pos];
    del0      = cmd.listed ? ((cmd.kind == KIND_VSIGN) && held) : drop0;
    priority if (cmd.cp == CP_ZWJ) begin
      mode0 = MODE_SKIP;
    end else if (edit0) begin
      mode0 = MODE_EDIT;
    end else if (!cmd.listed && (cmd.cp == CP_NULL)) begin
      mode0 = MODE_FLUSH;
    end else begin
      mode0 = MODE_PUSH;
    end
    mode      = first ? mode0 : mode_r;
    cnt_eff   = first ? (count_r - CW'(del0)) : count_r;
    shifted   = cmd.bytes << {step_r[1:0], 3'b000};
    push_byte = shifted[31:24];
    full      = (cnt_eff == FULL);
    push_last = (SW'(cmd.nbytes) == step_r + SW'(1));
  end

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    prev_nxt    = prev_r;
    emitted_nxt = emitted_r;
    isa_nxt     = isa_r;
    step_nxt    = step_r;
    mode_nxt    = mode_r;
    done        = 1'b0;
    emit        = '0;
    ram_we      = 1'b0;
    ram_waddr   = head_r;
    ram_wdata   = push_byte;
    ram_raddr   = head_r;

    if (cmd_valid) begin
      mode_nxt = mode;
      unique case (mode)
        MODE_SKIP: begin
          done = 1'b1;
        end
        MODE_PUSH: begin
          if (cmd.nbytes == 3'd0) begin
            done      = 1'b1;
            count_nxt = cnt_eff;
            prev_nxt  = cmd.cp;
          end else if (!full || credit_ok) begin
            ram_we = 1'b1;
            if (first) begin
              prev_nxt = cmd.cp;
            end
            if (full) begin
              ram_waddr   = head_r;
              ram_raddr   = head_r;
              emit.valid  = 1'b1;
              head_nxt    = pos(head_r, CW'(1));
              emitted_nxt = 1'b1;
              count_nxt   = cnt_eff;
            end else begin
              ram_waddr = pos(head_r, cnt_eff);
              count_nxt = cnt_eff + CW'(1);
            end
            if (push_last) begin
              done = 1'b1;
            end else begin
              step_nxt = step_r + SW'(1);
            end
          end
        end
        MODE_EDIT: begin
          if (first) begin
            prev_nxt = cmd.cp;
            done     = 1'b1;
            if (prev_r == CP_JA) begin
              if (count_r >= CW'(2)) begin
                ram_we    = 1'b1;
                ram_waddr = pos(head_r, count_r - CW'(2));
                ram_wdata = CH_Z;
              end
            end else if (prev_r == CP_JHA) begin
              if (count_r >= CW'(3)) begin
                ram_we    = 1'b1;
                ram_waddr = pos(head_r, count_r - CW'(3));
                ram_wdata = CH_Z;
              end
            end else if (prev_r == CP_PHA) begin
              if (count_r >= CW'(3)) begin
                ram_we    = 1'b1;
                ram_waddr = pos(head_r, count_r - CW'(3));
                ram_wdata = CH_F;
                done      = 1'b0;
                step_nxt  = step_r + SW'(1);
              end
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pos(head_r, count_r - CW'(2));
            ram_wdata = CH_SCHWA;
            count_nxt = count_r - CW'(1);
            done      = 1'b1;
          end
        end
        MODE_FLUSH: begin
          if (credit_ok) begin
            emit.valid = 1'b1;
            if (step_r < SW'(cnt_eff)) begin
              ram_raddr = pos(head_r, CW'(step_r));
              count_nxt = cnt_eff;
              step_nxt  = step_r + SW'(1);
            end else begin
              emit.lit    = 1'b1;
              emit.last   = 1'b1;
              emit.data   = CH_NUL;
              done        = 1'b1;
              count_nxt   = '0;
              head_nxt    = '0;
              prev_nxt    = CP_NULL;
              emitted_nxt = 1'b0;
            end
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    if (ram_we) begin
      isa_nxt[ram_waddr] = (ram_wdata == CH_SCHWA);
    end
    if (done) begin
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      prev_r    <= CP_NULL;
      emitted_r <= 1'b0;
      isa_r     <= '{default: 1'b0};
      step_r    <= '0;
      mode_r    <= MODE_SKIP;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      prev_r    <= prev_nxt;
      emitted_r <= emitted_nxt;
      isa_r     <= isa_nxt;
      step_r    <= step_nxt;
      mode_r    <= mode_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/dlt_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transcriber output queue
// Joins RAM read data with literal bytes and queues them for the result
// channel, granting issue credit to the sequencer.
// ----------------------------------------------------------------------------
module dlt_out (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dlt_pkg::emit_t emit,
  input  wire logic [7:0]     ram_rdata,
  output logic                credit_ok,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_last,
  input  wire logic           out_stall
);
  import dlt_pkg::*;

  logic               p_valid_r;
  logic               p_lit_r;
  logic               p_last_r;
  logic [7:0]         p_data_r;
  logic [8:0]         fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               push;
  logic               pop;
  logic [7:0]         push_data;

  assign push      = p_valid_r;
  assign pop       = out_valid && !out_stall;
  assign push_data = p_lit_r ? p_data_r : ram_rdata;
  assign credit_ok = (cnt_r + (FIFO_AW+1)'(p_valid_r)) < (FIFO_AW+1)'(FIFO_DEPTH);

  always_comb begin
    wr_nxt  = push ? wr_r + FIFO_AW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      wr_r      <= '0;
      rd_r      <= '0;
      cnt_r     <= '0;
    end else begin
      p_valid_r <= emit.valid;
      wr_r      <= wr_nxt;
      rd_r      <= rd_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_lit_r  <= emit.lit;
    p_last_r <= emit.last;
    p_data_r <= emit.data;
    if (push) begin
      fifo_r[wr_r] <= {p_last_r, push_data};
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_byte  = fifo_r[rd_r][7:0];
  assign out_last  = fifo_r[rd_r][8];

endmodule
`default_nettype wire

>>> src/devanagari_to_latin_transcriber.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Devanagari to Latin transcriber
// Turns a stream of Unicode code points into a Latin byte stream.
// ----------------------------------------------------------------------------
// Each item is one code point; each result is one byte, with out_last set on
// the zero byte that ends a string (sent for code point 0). The newest
// HOLD_DEPTH bytes are kept in a small ring RAM so that vowel signs, the final
// inherent a and the nukta can still edit them; older bytes leave as new ones
// arrive. An item writes its bytes to the ring one at a time through the
// single RAM write port; a nukta that rewrites pha first writes f and then
// moves the inherent a, and the end of a string reads out each held byte and
// then sends the terminator. A step that releases a byte waits while the
// result queue has no room. The result channel is decoupled by a four-entry
// queue, and no clearing pass follows reset.
module devanagari_to_latin_transcriber #(
  parameter int HOLD_DEPTH = 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [dlt_pkg::CP_W-1:0]  in_code_point,
  output logic                           in_stall,
  output logic                           out_valid,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  input  wire logic                      out_stall
);
  import dlt_pkg::*;

  localparam int AW = $clog2(HOLD_DEPTH);

  logic          done;
  logic          cmd_valid;
  cmd_t          cmd;
  logic          credit_ok;
  emit_t         emit;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  dlt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_code_point (in_code_point),
    .in_stall      (in_stall),
    .done          (done),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  dlt_seq #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .done      (done),
    .credit_ok (credit_ok),
    .emit      (emit),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  dlt_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dlt_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .ram_rdata (ram_rdata),
    .credit_ok (credit_ok),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire
